@@ hw/rtl/lsf_pkg.sv @@
// lsf_pkg: shared types, codes and default sizes for the line fit core
// no dependencies; imported by every module of the block
package lsf_pkg;

  localparam int LSF_MAX_SAMPLES = 1024;
  localparam int LSF_SAMPLE_BITS = 16;
  localparam int LSF_FRAC_BITS   = 16;

  localparam int OUT_W = 48;
  localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FIT_OK       = 2'd0,
    FIT_ZERO_DEN = 2'd1,
    FIT_OVERFLOW = 2'd2
  } fit_status_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_SETTLE,
    ST_DEN_A,
    ST_DEN_B,
    ST_CHECK,
    ST_NUM_A,
    ST_NUM_B,
    ST_SLOPE,
    ST_INUM_A,
    ST_INUM_B,
    ST_ICPT,
    ST_OUT
  } lsf_state_t;

endpackage

@@ hw/rtl/lsf_acc.sv @@
// lsf_acc: running count and sums of x, y, x*y and x*x
// uses lsf_pkg; products are added in the cycle after the item is taken
module lsf_acc import lsf_pkg::*; #(
  parameter int MAX_SAMPLES = LSF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = LSF_SAMPLE_BITS,
  parameter int CW          = $clog2(LSF_MAX_SAMPLES + 1),
  parameter int SW          = LSF_SAMPLE_BITS + CW,
  parameter int PW          = 2 * LSF_SAMPLE_BITS + CW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          clear,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  logic signed [SAMPLE_BITS-1:0] y_in,
  output logic        [CW-1:0]          count,
  output logic signed [SW-1:0]          sum_x,
  output logic signed [SW-1:0]          sum_y,
  output logic signed [PW-1:0]          sum_xy,
  output logic signed [PW-1:0]          sum_xx,
  output logic                          overflow
);

  logic                          pend;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [2*SAMPLE_BITS-1:0] prod_xy;
  logic signed [2*SAMPLE_BITS-1:0] prod_xx;
  logic                          room;

  assign room    = (count < CW'(MAX_SAMPLES));
  assign prod_xy = x_r * y_r;
  assign prod_xx = x_r * x_r;

  always_ff @(posedge clk) begin
    x_r <= x_in;
    y_r <= y_in;
    if (rst || clear) begin
      count    <= '0;
      sum_x    <= '0;
      sum_y    <= '0;
      sum_xy   <= '0;
      sum_xx   <= '0;
      overflow <= 1'b0;
      pend     <= 1'b0;
    end else begin
      pend <= take && room;
      if (take) begin
        if (room) begin
          count <= count + CW'(1);
          sum_x <= sum_x + SW'(x_in);
          sum_y <= sum_y + SW'(y_in);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (pend) begin
        sum_xy <= sum_xy + PW'(prod_xy);
        sum_xx <= sum_xx + PW'(prod_xx);
      end
    end
  end

endmodule

@@ hw/rtl/lsf_mul.sv @@
// lsf_mul: serial signed multiplier, one bit of b per cycle, msb first
// uses lsf_pkg; product is exact modulo 2**AW
module lsf_mul import lsf_pkg::*; #(
  parameter int AW = 71,
  parameter int BW = 43
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 done,
  output logic signed [AW-1:0] product
);

  localparam int CNTW = $clog2(BW);

  logic signed [AW-1:0] a_r;
  logic        [BW-1:0] b_sh;
  logic        [CNTW-1:0] cnt;
  logic                 active;
  logic                 first;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] acc_next;

  // sign bit of b has negative weight
  always_comb begin
    if (b_sh[BW-1]) begin
      addend = first ? -a_r : a_r;
    end else begin
      addend = '0;
    end
    acc_next = {product[AW-2:0], 1'b0} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      first  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r     <= a;
        b_sh    <= b;
        product <= '0;
        cnt     <= CNTW'(BW - 1);
        active  <= 1'b1;
        first   <= 1'b1;
      end else if (active) begin
        product <= acc_next;
        b_sh    <= {b_sh[BW-2:0], 1'b0};
        first   <= 1'b0;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - CNTW'(1);
        end
      end
    end
  end

endmodule

@@ hw/rtl/lsf_div.sv @@
// lsf_div: serial restoring divider, one quotient bit per cycle
// uses lsf_pkg; gives numer/denom with FRAC_BITS fraction bits, saturated
module lsf_div import lsf_pkg::*; #(
  parameter int WW        = 71,
  parameter int FRAC_BITS = LSF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [WW-1:0]    numer,
  input  logic signed [WW-1:0]    denom,
  output logic                    done,
  output logic signed [OUT_W-1:0] ratio
);

  localparam int QW   = WW + FRAC_BITS;
  localparam int QX   = (QW > OUT_W) ? QW : OUT_W + 1;
  localparam int CNTW = $clog2(QW);

  logic [WW-1:0]   rem;
  logic [QW-1:0]   quo;
  logic [WW-1:0]   dmag;
  logic            neg;
  logic [CNTW-1:0] cnt;
  logic            active;
  logic            finish;

  logic [WW-1:0]    num_mag;
  logic [WW-1:0]    den_mag;
  logic [WW:0]      rem_sh;
  logic [WW:0]      diff;
  logic             ge;
  logic [QX-1:0]    q_ext;
  logic [OUT_W-1:0] ratio_next;

  always_comb begin
    num_mag = numer[WW-1] ? WW'(-numer) : WW'(numer);
    den_mag = denom[WW-1] ? WW'(-denom) : WW'(denom);
    rem_sh  = {rem, quo[QW-1]};
    diff    = rem_sh - {1'b0, dmag};
    ge      = !diff[WW];
    q_ext   = QX'(quo);
    if (neg) begin
      if (q_ext > QX'(NEG_LIMIT)) begin
        ratio_next = NEG_LIMIT;
      end else begin
        ratio_next = OUT_W'(QX'(0) - q_ext);
      end
    end else begin
      if (q_ext > QX'(POS_LIMIT)) begin
        ratio_next = POS_LIMIT;
      end else begin
        ratio_next = q_ext[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      finish <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= '0;
        quo    <= QW'(num_mag) << FRAC_BITS;
        dmag   <= den_mag;
        neg    <= numer[WW-1] ^ denom[WW-1];
        cnt    <= CNTW'(QW - 1);
        active <= 1'b1;
      end else if (active) begin
        rem <= ge ? diff[WW-1:0] : rem_sh[WW-1:0];
        quo <= {quo[QW-2:0], ge};
        if (cnt == '0) begin
          active <= 1'b0;
          finish <= 1'b1;
        end else begin
          cnt <= cnt - CNTW'(1);
        end
      end else if (finish) begin
        ratio  <= $signed(ratio_next);
        finish <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/least_squares_line_fit_core.sv @@
// least_squares_line_fit_core: least-squares line fit over a stream of samples
// samples are taken one per cycle while in_ready is high; the item marked last
// starts the fit, during which in_ready is low; the fit runs on the serial
// multiplier (PW bits) and divider (WW+FRAC_BITS bits)
// the result waits in an output register while the next set is accumulated
// rst is synchronous: clears all sums, the sequencer and the output valid
module least_squares_line_fit_core import lsf_pkg::*; #(
  parameter int MAX_SAMPLES = LSF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = LSF_SAMPLE_BITS,
  parameter int FRAC_BITS   = LSF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] x_value,
  input  logic signed [SAMPLE_BITS-1:0] y_value,
  input  logic                          last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       slope,
  output logic signed [OUT_W-1:0]       intercept,
  output logic        [1:0]             fit_status
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = SAMPLE_BITS + CW;
  localparam int PW = 2 * SAMPLE_BITS + CW;
  localparam int WW = SW + PW + 1;

  lsf_state_t state, state_next;
  logic       launched, launched_next;

  logic                 take;
  logic                 clear;
  logic                 load_out;
  logic [CW-1:0]        count;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [PW-1:0] sum_xy;
  logic signed [PW-1:0] sum_xx;
  logic                 overflow;

  logic                 mul_start;
  logic                 mul_done;
  logic signed [WW-1:0] mul_a;
  logic signed [PW-1:0] mul_b;
  logic signed [WW-1:0] mul_p;
  logic                 div_start;
  logic                 div_done;
  logic signed [OUT_W-1:0] div_q;

  logic signed [WW-1:0]    hold;
  logic signed [WW-1:0]    den_r;
  logic signed [WW-1:0]    numer;
  logic signed [WW-1:0]    diff;
  logic signed [OUT_W-1:0] slope_r;
  logic signed [OUT_W-1:0] icpt_r;
  fit_status_t             status_r;

  assign take = in_valid && in_ready;
  assign diff = hold - mul_p;

  lsf_acc #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW),
    .SW          (SW),
    .PW          (PW)
  ) u_acc (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .clear    (clear),
    .x_in     (x_value),
    .y_in     (y_value),
    .count    (count),
    .sum_x    (sum_x),
    .sum_y    (sum_y),
    .sum_xy   (sum_xy),
    .sum_xx   (sum_xx),
    .overflow (overflow)
  );

  lsf_mul #(
    .AW (WW),
    .BW (PW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  lsf_div #(
    .WW        (WW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (den_r),
    .done  (div_done),
    .ratio (div_q)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      ST_DEN_A: begin
        mul_a = WW'(sum_xx);
        mul_b = PW'(count);
      end
      ST_DEN_B: begin
        mul_a = WW'(sum_x);
        mul_b = PW'(sum_x);
      end
      ST_NUM_A: begin
        mul_a = WW'(sum_xy);
        mul_b = PW'(count);
      end
      ST_NUM_B: begin
        mul_a = WW'(sum_y);
        mul_b = PW'(sum_x);
      end
      ST_INUM_A: begin
        mul_a = WW'(sum_y);
        mul_b = sum_xx;
      end
      ST_INUM_B: begin
        mul_a = WW'(sum_x);
        mul_b = sum_xy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACC;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  always_comb begin
    state_next    = state;
    launched_next = launched;
    in_ready      = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    clear         = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid && last_sample) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_next = overflow ? ST_OUT : ST_DEN_A;
      end
      ST_DEN_A, ST_DEN_B, ST_NUM_A, ST_NUM_B, ST_INUM_A, ST_INUM_B: begin
        if (!launched) begin
          mul_start     = 1'b1;
          launched_next = 1'b1;
        end else if (mul_done) begin
          launched_next = 1'b0;
          case (state)
            ST_DEN_A:  state_next = ST_DEN_B;
            ST_DEN_B:  state_next = ST_CHECK;
            ST_NUM_A:  state_next = ST_NUM_B;
            ST_NUM_B:  state_next = ST_SLOPE;
            ST_INUM_A: state_next = ST_INUM_B;
            default:   state_next = ST_ICPT;
          endcase
        end
      end
      ST_CHECK: begin
        state_next = (den_r == '0) ? ST_OUT : ST_NUM_A;
      end
      ST_SLOPE, ST_ICPT: begin
        if (!launched) begin
          div_start     = 1'b1;
          launched_next = 1'b1;
        end else if (div_done) begin
          launched_next = 1'b0;
          state_next    = (state == ST_SLOPE) ? ST_INUM_A : ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          clear      = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  // fit datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_SETTLE: begin
        status_r <= FIT_OVERFLOW;
        slope_r  <= '0;
        icpt_r   <= '0;
      end
      ST_DEN_A, ST_NUM_A, ST_INUM_A: begin
        if (mul_done) begin
          hold <= mul_p;
        end
      end
      ST_DEN_B: begin
        if (mul_done) begin
          den_r <= diff;
        end
      end
      ST_NUM_B, ST_INUM_B: begin
        if (mul_done) begin
          numer <= diff;
        end
      end
      ST_CHECK: begin
        status_r <= FIT_ZERO_DEN;
      end
      ST_SLOPE: begin
        if (div_done) begin
          slope_r <= div_q;
        end
      end
      ST_ICPT: begin
        if (div_done) begin
          icpt_r   <= div_q;
          status_r <= FIT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      slope      <= slope_r;
      intercept  <= icpt_r;
      fit_status <= status_r;
    end
  end

endmodule

@@ hw/rtl/lsf_checker.sv @@
// lsf_checker: port-level checks on the line fit core
// uses lsf_pkg; bound to least_squares_line_fit_core below
module lsf_checker import lsf_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    last_sample,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] slope,
  input logic signed [OUT_W-1:0] intercept,
  input logic [1:0]              fit_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slope) && $stable(intercept)
      && $stable(fit_status))
    else $error("result changed while stalled");

  // a failed fit carries zero slope and intercept
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fit_status != FIT_OK |-> slope == '0 && intercept == '0)
    else $error("failed fit with nonzero values");

  // the fit stalls input after the last item
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_sample |=> !in_ready)
    else $error("ready after last item");

  // ordinary items stream one per cycle
  a_stream: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_sample |=> in_ready)
    else $error("ready dropped during accumulation");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind least_squares_line_fit_core lsf_checker u_lsf_checker (.*);
